// ----- design/csw_pkg.sv -----
// ----------------------------------------------------------------------------
// Console stop-and-wait packetiser: shared definitions
// Sizes, codes and the item and control structures used by every file of
// the console transmit block but the generic RAM.
// ----------------------------------------------------------------------------
package csw_pkg;

  // Ring geometry. The ring is split into interleaved banks so that one
  // frame's worth of consecutive bytes can be read in one access. The
  // depth must be a multiple of the bank count.
  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MAX_PAYLOAD  = 4;
  localparam int unsigned NUM_BANKS    = MAX_PAYLOAD;
  localparam int unsigned IDX_W        = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int unsigned BANK_W       = $clog2(NUM_BANKS);
  localparam int unsigned ROW_DEPTH    = RING_DEPTH / NUM_BANKS;
  localparam int unsigned ROW_W        = IDX_W - BANK_W;

  // Field widths.
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Input kinds.
  localparam logic [2:0] KIND_LOG   = 3'd0;
  localparam logic [2:0] KIND_TTY   = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_CLUSTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_MODULE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_NODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_OBJECT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_CLUSTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_MODULE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_NODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd7;

  // Characters and address values.
  localparam logic [7:0]        CH_NL  = 8'h0A;
  localparam logic [7:0]        CH_CR  = 8'h0D;
  localparam logic [NODE_W-1:0] UNCONN = 6'h3F;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_byte;
    logic       tty_stopped;
    logic       last_in_batch;
  } in_item_t;

  typedef struct packed {
    logic             packet_valid;
    logic [7:0]       data_byte0;
    logic [7:0]       data_byte1;
    logic [7:0]       data_byte2;
    logic [7:0]       data_byte3;
    logic [2:0]       data_count;
    logic [NODE_W-1:0] dest_node;
    logic [3:0]       frame_length;
    logic             char_accepted;
    logic             unexpected_ack;
    logic             ack_timed_out;
    logic [CNT_W-1:0] free_room;
  } out_item_t;

  // Settings derived from the configuration registers.
  typedef struct packed {
    logic              connected;
    logic [NODE_W-1:0] dest_node;
    logic [TICK_W-1:0] timeout_load;
  } cfg_view_t;

  // One ring bank's write and read request for the current item.
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [ROW_W-1:0] raddr;
  } bank_req_t;

  // Result of an item while its ring reads are in flight.
  typedef struct packed {
    logic                             packet_valid;
    logic [2:0]                       data_count;
    logic [NODE_W-1:0]                dest_node;
    logic                             char_accepted;
    logic                             unexpected_ack;
    logic                             ack_timed_out;
    logic [CNT_W-1:0]                 free_room;
    logic [BANK_W-1:0]                first_bank;
    logic [MAX_PAYLOAD-1:0]           fwd_hit;
    logic [MAX_PAYLOAD-1:0][7:0]      fwd_data;
  } meta_t;

endpackage

// ----- design/csw_if.sv -----
// ----------------------------------------------------------------------------
// Console packetiser channels
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface csw_in_if
  import csw_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface csw_out_if
  import csw_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/csw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port; the read data is registered and holds while
// no read is enabled. A read of the address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
module csw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/csw_cfg.sv -----
// ----------------------------------------------------------------------------
// Console packetiser configuration registers
// Holds the peer and local addresses and the acknowledge timeout, and
// derives the connection, destination and timer load values.
// ----------------------------------------------------------------------------
module csw_cfg
  import csw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_view_t             view_o
);

  logic [NODE_W-1:0] tgt_cluster_q, tgt_module_q, tgt_node_q, tgt_object_q;
  logic [NODE_W-1:0] loc_cluster_q, loc_module_q, bridge_node_q;
  logic [TICK_W-1:0] ack_timeout_q;
  logic              peer_local;

  // Register writes by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_cluster_q <= UNCONN;
      tgt_module_q  <= UNCONN;
      tgt_node_q    <= UNCONN;
      tgt_object_q  <= UNCONN;
      loc_cluster_q <= '0;
      loc_module_q  <= '0;
      bridge_node_q <= '0;
      ack_timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TGT_CLUSTER: tgt_cluster_q <= cfg_data_i[NODE_W-1:0];
        CFG_TGT_MODULE:  tgt_module_q  <= cfg_data_i[NODE_W-1:0];
        CFG_TGT_NODE:    tgt_node_q    <= cfg_data_i[NODE_W-1:0];
        CFG_TGT_OBJECT:  tgt_object_q  <= cfg_data_i[NODE_W-1:0];
        CFG_LOC_CLUSTER: loc_cluster_q <= cfg_data_i[NODE_W-1:0];
        CFG_LOC_MODULE:  loc_module_q  <= cfg_data_i[NODE_W-1:0];
        CFG_BRIDGE_NODE: bridge_node_q <= cfg_data_i[NODE_W-1:0];
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // The peer is unconnected when all four of its address fields are all ones.
  assign view_o.connected = !((tgt_cluster_q == UNCONN) && (tgt_module_q == UNCONN) &&
                              (tgt_node_q == UNCONN) && (tgt_object_q == UNCONN));

  // Frames go straight to the peer when it sits in our cluster and module.
  assign peer_local       = (tgt_cluster_q == loc_cluster_q) && (tgt_module_q == loc_module_q);
  assign view_o.dest_node = peer_local ? tgt_node_q : bridge_node_q;

  // A zero timeout still waits one tick.
  assign view_o.timeout_load = (ack_timeout_q == '0) ? TICK_W'(1) : ack_timeout_q;

endmodule

// ----- design/csw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Console packetiser item control
// Updates the ring pointers, the acknowledge flag and the timer for one
// item, and issues the ring bank writes and the frame reads.
// ----------------------------------------------------------------------------
module csw_ctrl
  import csw_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  in_item_t                        item_i,
  input  cfg_view_t                       cfg_i,
  output bank_req_t [NUM_BANKS-1:0]       bank_req_o,
  output meta_t                           meta_o
);

  logic [IDX_W-1:0]  ridx_q, ridx_d, widx_q, widx_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              ackw_q, ackw_d;
  logic [TICK_W-1:0] tleft_q, tleft_d;

  // Ring index plus a small offset, wrapping at the ring depth.
  function automatic logic [IDX_W-1:0] idx_add(logic [IDX_W-1:0] idx, logic [2:0] k);
    logic [IDX_W:0] s;
    s = {1'b0, idx} + (IDX_W + 1)'(k);
    if (s >= (IDX_W + 1)'(RING_DEPTH)) begin
      s = s - (IDX_W + 1)'(RING_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // Per-item logic: character stores first, then the send attempt.
  always_comb begin
    logic             w0_en, w1_en;
    logic [7:0]       w0_data, w1_data;
    logic [IDX_W-1:0] w0_addr, w1_addr;
    logic [1:0]       nwr;
    logic             room0, room1, ch_ok, send;
    logic             ackw_mid;
    logic [CNT_W-1:0] fill_mid;
    logic [2:0]       n;
    logic [IDX_W-1:0] ra;

    w0_en    = 1'b0;
    w1_en    = 1'b0;
    w0_data  = item_i.char_byte;
    w1_data  = item_i.char_byte;
    w0_addr  = widx_q;
    w1_addr  = idx_add(widx_q, 3'd1);
    room0    = fill_q < CNT_W'(RING_DEPTH);
    room1    = fill_q < CNT_W'(RING_DEPTH - 1);
    ch_ok    = 1'b0;
    send     = 1'b0;
    ackw_mid = ackw_q;
    tleft_d  = tleft_q;
    n        = '0;

    meta_o = '0;

    unique case (item_i.kind)
      KIND_LOG: begin
        if (cfg_i.connected) begin
          // A newline first stores a carriage return.
          if ((item_i.char_byte == CH_NL) && room0) begin
            w0_en   = 1'b1;
            w0_data = CH_CR;
            ch_ok   = room1;
            w1_en   = room1;
          end else begin
            ch_ok = room0;
            w0_en = room0;
          end
          meta_o.char_accepted = ch_ok;
          send = item_i.last_in_batch;
        end
      end
      KIND_TTY: begin
        if (!cfg_i.connected) begin
          meta_o.char_accepted = 1'b1;
        end else if (!item_i.tty_stopped) begin
          ch_ok = room0;
          w0_en = room0;
          meta_o.char_accepted = ch_ok;
          send = item_i.last_in_batch || !ch_ok;
        end
      end
      KIND_ACK: begin
        meta_o.unexpected_ack = !ackw_q;
        ackw_mid = 1'b0;
        tleft_d  = '0;
        send     = 1'b1;
      end
      KIND_TICK: begin
        if (ackw_q) begin
          if (tleft_q != '0) begin
            tleft_d = tleft_q - TICK_W'(1);
          end
          if (tleft_d == '0) begin
            ackw_mid = 1'b0;
            meta_o.ack_timed_out = 1'b1;
            send = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Pointer advance after the stores.
    nwr      = {1'b0, w0_en} + {1'b0, w1_en};
    fill_mid = fill_q + CNT_W'(nwr);
    unique case (nwr)
      2'd1:    widx_d = w1_addr;
      2'd2:    widx_d = idx_add(widx_q, 3'd2);
      default: widx_d = widx_q;
    endcase
    ridx_d = ridx_q;
    fill_d = fill_mid;
    ackw_d = ackw_mid;

    // Flush empties the ring without touching the acknowledge state.
    if (item_i.kind == KIND_FLUSH) begin
      ridx_d = widx_q;
      fill_d = '0;
    end

    // Send attempt: an unconnected peer drains the ring, otherwise a frame of
    // up to four bytes leaves when nothing is pending.
    if (send) begin
      if (!cfg_i.connected) begin
        ridx_d = widx_d;
        fill_d = '0;
      end else if (!ackw_mid && (fill_mid != '0)) begin
        n = (fill_mid >= CNT_W'(MAX_PAYLOAD)) ? 3'(MAX_PAYLOAD) : fill_mid[2:0];
        ridx_d  = idx_add(ridx_q, n);
        fill_d  = fill_mid - CNT_W'(n);
        ackw_d  = 1'b1;
        tleft_d = cfg_i.timeout_load;
        meta_o.packet_valid = 1'b1;
        meta_o.data_count   = n;
        meta_o.dest_node    = cfg_i.dest_node;
      end
    end

    meta_o.free_room  = CNT_W'(RING_DEPTH) - fill_d;
    meta_o.first_bank = ridx_q[BANK_W-1:0];

    // Bank requests: each of the consecutive frame bytes and each store lands
    // in its own bank.
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_req_o[b] = '0;
    end
    if (w0_en) begin
      bank_req_o[w0_addr[BANK_W-1:0]].we    = 1'b1;
      bank_req_o[w0_addr[BANK_W-1:0]].waddr = w0_addr[IDX_W-1:BANK_W];
      bank_req_o[w0_addr[BANK_W-1:0]].wdata = w0_data;
    end
    if (w1_en) begin
      bank_req_o[w1_addr[BANK_W-1:0]].we    = 1'b1;
      bank_req_o[w1_addr[BANK_W-1:0]].waddr = w1_addr[IDX_W-1:BANK_W];
      bank_req_o[w1_addr[BANK_W-1:0]].wdata = w1_data;
    end
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      ra = idx_add(ridx_q, 3'(k));
      bank_req_o[ra[BANK_W-1:0]].raddr = ra[IDX_W-1:BANK_W];
      // A byte stored by this same item is not yet in the bank when read.
      if (w0_en && (w0_addr == ra)) begin
        meta_o.fwd_hit[k]  = 1'b1;
        meta_o.fwd_data[k] = w0_data;
      end else if (w1_en && (w1_addr == ra)) begin
        meta_o.fwd_hit[k]  = 1'b1;
        meta_o.fwd_data[k] = w1_data;
      end
    end
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q  <= '0;
      widx_q  <= '0;
      fill_q  <= '0;
      ackw_q  <= 1'b0;
      tleft_q <= '0;
    end else if (fire_i) begin
      ridx_q  <= ridx_d;
      widx_q  <= widx_d;
      fill_q  <= fill_d;
      ackw_q  <= ackw_d;
      tleft_q <= tleft_d;
    end
  end

  // The timer runs exactly while an acknowledge is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ackw_q == (tleft_q != '0))
    else $error("acknowledge flag and timer disagree");

  // The fill count never exceeds the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CNT_W'(RING_DEPTH))
    else $error("ring fill count overflow");

  // The read pointer trails the write pointer by the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_add(ridx_q, 3'd0) ==
      IDX_W'(({1'b0, widx_q} + (IDX_W + 1)'(RING_DEPTH) - (IDX_W + 1)'(fill_q)) % RING_DEPTH))
    else $error("ring pointers out of step with fill count");

endmodule

// ----- design/console_stop_wait_packetizer.sv -----
// ----------------------------------------------------------------------------
// Console stop-and-wait packetiser
// Console transmit engine: queues log and terminal characters in a byte ring
// and packs up to four of them into a frame per acknowledge.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_i (valid/ready): characters, acknowledges, timer ticks
// and flush requests. Every item yields exactly one result on out_o, which
// carries an optional frame plus the status flags and the free ring room.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; a write takes effect at the next clock edge.
// Timing: the accepting edge does the item's control work and issues its
// ring read into the middle stage; the output register then loads from the
// middle stage once it is free and presents the result. Throughput: one
// item per cycle while out_o does not stall; the ring is four interleaved
// banks, so the four bytes of a frame come out of one read.
// Reset empties the ring, clears the pending acknowledge and the timer and
// restores the register defaults (peer unconnected). The ring contents are
// not cleared. When out_o stalls, the result waits in the output register,
// one more item can fill an empty middle stage, and then in_i.ready drops.
// ----------------------------------------------------------------------------
module console_stop_wait_packetizer
  import csw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  csw_in_if.sink                in_i,
  csw_out_if.source             out_o
);

  cfg_view_t                    cfg_view;
  bank_req_t [NUM_BANKS-1:0]    bank_req;
  logic [NUM_BANKS-1:0][7:0]    bank_rdata;
  meta_t                        meta, s1_q;
  logic                         s1_valid_q, out_valid_q;
  out_item_t                    out_q, out_d;
  logic                         fire, out_adv;
  logic [MAX_PAYLOAD-1:0][7:0]  payload;

  csw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .view_o     (cfg_view)
  );

  csw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_i.payload),
    .cfg_i      (cfg_view),
    .bank_req_o (bank_req),
    .meta_o     (meta)
  );

  // Interleaved ring banks; reads are only issued by an accepted item, so
  // the read data holds while the middle stage is stalled.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    csw_ram #(
      .WIDTH (8),
      .DEPTH (ROW_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (fire && bank_req[b].we),
      .waddr_i (bank_req[b].waddr),
      .wdata_i (bank_req[b].wdata),
      .re_i    (fire),
      .raddr_i (bank_req[b].raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // Handshake: the output register frees the middle stage, which frees input.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign fire       = in_i.valid && in_i.ready;

  // Payload assembly: rotate bank data into ring order, take same-item
  // stores from the forward path, and zero the unused bytes.
  always_comb begin
    logic [BANK_W-1:0] bank;
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      bank = s1_q.first_bank + BANK_W'(k);
      payload[k] = s1_q.fwd_hit[k] ? s1_q.fwd_data[k] : bank_rdata[bank];
      if (3'(k) >= s1_q.data_count) begin
        payload[k] = '0;
      end
    end
  end

  always_comb begin
    out_d                = '0;
    out_d.packet_valid   = s1_q.packet_valid;
    out_d.data_byte0     = payload[0];
    out_d.data_byte1     = payload[1];
    out_d.data_byte2     = payload[2];
    out_d.data_byte3     = payload[3];
    out_d.data_count     = s1_q.data_count;
    out_d.dest_node      = s1_q.dest_node;
    out_d.frame_length   = s1_q.packet_valid ?
                           (4'(HEADER_BYTES) + 4'(s1_q.data_count)) : 4'd0;
    out_d.char_accepted  = s1_q.char_accepted;
    out_d.unexpected_ack = s1_q.unexpected_ack;
    out_d.ack_timed_out  = s1_q.ack_timed_out;
    out_d.free_room      = s1_q.free_room;
  end

  // Middle stage and output register valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= fire;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q <= meta;
    end
    if (out_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // A frame on the output always carries between one and four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.packet_valid) |->
      (out_q.data_count != 3'd0) && (out_q.data_count <= 3'(MAX_PAYLOAD)))
    else $error("frame with bad payload count");

  // Without a frame every frame field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.packet_valid) |->
      (out_q.data_count == 3'd0) && (out_q.frame_length == 4'd0) &&
      (out_q.dest_node == '0) && (out_q.data_byte0 == 8'd0))
    else $error("frame fields set without a frame");

endmodule
